>>> src/integer_square_root_macros.svh
// Assertion macros for the integer square root block.
// Used by the controller; expects clk_i and rst_ni in scope.
`ifndef INTEGER_SQUARE_ROOT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_MACROS_SVH

// Checked only outside reset.
`define ISR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, including during reset.
`define ISR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/isr_pkg.sv
// Shared types and constants for the integer square root block.
// No dependencies.
`timescale 1ns / 1ps

package isr_pkg;

  localparam int unsigned RAD_W = 64;
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W = ROOT_W + 1;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } isr_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } isr_cmd_t;

endpackage

>>> src/integer_square_root.sv
// Integer square root: top level joining controller and datapath.
// Depends on isr_pkg, isr_ctrl and isr_datapath.
//
// Input channel: radicand_i (signed 64 bits) with in_valid_i / in_stall_o.
// Output channel: root_o (unsigned 32 bits) with out_valid_o / out_stall_i.
// A beat moves at a rising edge where valid is high and stall is low.
// Each radicand gives exactly one root, floor(sqrt(radicand)); zero and
// negative radicands give 0.
// A new radicand is taken only as the previous one finishes, set by the
// single shared add/compare stage that resolves one root bit per cycle,
// except while the last step waits for the output register to free.
// The finished root sits in an output register, so the next radicand is
// taken in the cycle the previous one finishes, even if the root waits.
// If the receiver stalls and a second root completes, the datapath holds on
// its last step and in_stall_o stays high until the output register frees.
// Reset (rst_ni low, asynchronous) empties the output and returns to idle.
`timescale 1ns / 1ps

module integer_square_root
  import isr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROOT_W-1:0] root_o
);

  isr_cmd_t cmd;

  isr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  isr_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .radicand_i (radicand_i),
    .root_o     (root_o)
  );

endmodule

>>> src/isr_datapath.sv
// Datapath: restoring digit-by-digit square root, one root bit per step,
// plus the output result register. Depends on isr_pkg.
`timescale 1ns / 1ps

module isr_datapath
  import isr_pkg::*;
(
  input  logic              clk_i,
  input  isr_cmd_t          cmd_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d, out_root_q;

  logic [REM_W+1:0]  rem_sh;
  logic [ROOT_W-1:0] root_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              take;

  always_comb begin
    rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
    root_sh = {root_q[ROOT_W-2:0], 1'b0};
    trial   = {2'b00, root_sh, 1'b1};
    diff    = rem_sh - trial;
    take    = (rem_sh >= trial);
    root_d  = {root_sh[ROOT_W-1:1], take};
    rem_d   = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    rad_d   = {rad_q[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_root_q <= root_d;
    end
    if (cmd_i.load) begin
      // non-positive radicands run as zero
      rad_q  <= radicand_i[RAD_W-1] ? '0 : radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.step) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = out_root_q;

endmodule

>>> src/isr_ctrl.sv
// Controller: sequences the 32 root steps and owns both handshakes.
// Depends on isr_pkg and integer_square_root_macros.svh.
`timescale 1ns / 1ps
`include "integer_square_root_macros.svh"

module isr_ctrl
  import isr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output isr_cmd_t cmd_o
);

  isr_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             last, out_free, fin, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    last       = (state_q == ST_RUN) && (cnt_q == '0);
    out_free   = !out_valid_q || !out_stall_i;
    fin        = last && out_free;
    in_stall_o = !((state_q == ST_IDLE) || fin);
    accept     = in_valid_i && !in_stall_o;

    cmd_o.load     = accept;
    cmd_o.step     = (state_q == ST_RUN) && (!last || out_free);
    cmd_o.out_load = fin;

    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fin) begin
          state_d = accept ? ST_RUN : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (accept) begin
      cnt_d = CNT_W'(ROOT_W - 1);
    end else if (cmd_o.step) begin
      cnt_d = cnt_q - 1'b1;
    end

    if (fin) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ISR_ASSERT(a_accept_starts_run, accept |=> (state_q == ST_RUN) && (cnt_q == CNT_W'(ROOT_W - 1)), "accepted beat did not start a full run")
  `ISR_ASSERT(a_no_overwrite, cmd_o.out_load |-> (!out_valid_q || !out_stall_i), "waiting result overwritten")
  `ISR_ASSERT(a_result_shown, cmd_o.out_load |=> out_valid_q, "finished result not presented")
  `ISR_ASSERT_ALWAYS(a_idle_no_step, (state_q == ST_IDLE) |-> !cmd_o.step && !cmd_o.out_load, "step issued while idle")

endmodule

>>> sim/tb_integer_square_root.sv
// Self-checking testbench for integer_square_root: directed edge radicands, then random beats.
// Expected roots come from a local bit-serial floor root. Depends on isr_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_integer_square_root;
  import isr_pkg::*;

  localparam logic [ROOT_W-1:0] ROOT_MAX = 32'd3037000499;
  localparam int RANDOM_BEATS = 1000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [RAD_W-1:0] value;
    bit               drain;
  } radicand_beat_t;

  typedef struct {
    logic [RAD_W-1:0]  radicand;
    logic [ROOT_W-1:0] root;
  } root_due_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [RAD_W-1:0]  radicand_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ROOT_W-1:0] root_o;

  radicand_beat_t pending_radicands[$];
  root_due_t      roots_due[$];
  radicand_beat_t next_beat;
  root_due_t      oldest_root;
  logic           in_taken;
  int             beats_sent;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             quiet_cycles;
  int             error_count;

  integer_square_root uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .radicand_i (radicand_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .root_o     (root_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Digit by digit, one root bit per pass; non-positive radicands give zero
  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [RAD_W-1:0] rad);
    logic [RAD_W+1:0]  rem;
    logic [RAD_W+1:0]  trial;
    logic [ROOT_W-1:0] acc;
    rem = '0;
    acc = '0;
    if ($signed(rad) <= 0) return '0;
    for (int k = ROOT_W - 1; k >= 0; k--) begin
      rem = (rem << 2) | (RAD_W + 2)'(rad[2*k+1 -: 2]);
      trial = (RAD_W + 2)'({acc, 2'b01});
      if (rem >= trial) begin
        rem = rem - trial;
        acc = {acc[ROOT_W-2:0], 1'b1};
      end else begin
        acc = {acc[ROOT_W-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  task automatic queue_radicand(input logic [RAD_W-1:0] value, input bit drain);
    radicand_beat_t beat;
    beat.value = value;
    beat.drain = drain;
    pending_radicands.push_back(beat);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  // Driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beats_sent < 350) begin
        send_idle_pct = 27;
        recv_stall_pct = 65;
      end else if (beats_sent < 700) begin
        send_idle_pct = 65;
        recv_stall_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (!in_valid_i || in_taken) begin
        if (pending_radicands.size() == 0 ||
            (pending_radicands[0].drain && roots_due.size() != 0) ||
            $urandom_range(99) < send_idle_pct) begin
          in_valid_i <= 1'b0;
        end else begin
          next_beat = pending_radicands.pop_front();
          in_valid_i <= 1'b1;
          radicand_i <= next_beat.value;
          beats_sent++;
        end
      end
    end
  end

  // Monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        roots_due.push_back('{radicand: radicand_i, root: floor_sqrt(radicand_i)});
      end
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (roots_due.size() == 0) begin
          report_mismatch($sformatf("unexpected root beat %0d", root_o));
        end else begin
          oldest_root = roots_due.pop_front();
          if (root_o !== oldest_root.root)
            report_mismatch($sformatf("root of %0d: got %0d, want %0d",
                                      $signed(oldest_root.radicand), root_o,
                                      oldest_root.root));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [RAD_W-1:0] r;
    int unsigned      sel;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    radicand_i = '0;
    out_stall_i = 1'b0;
    in_taken = 1'b0;
    beats_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    error_count = 0;

    // Edge cases: zero, one, negatives, extremes, squares at the top of the range
    queue_radicand(64'd0, 1'b0);
    queue_radicand(64'd1, 1'b0);
    queue_radicand(64'd2, 1'b0);
    queue_radicand(64'd3, 1'b0);
    queue_radicand(64'd4, 1'b0);
    queue_radicand('1, 1'b0);
    queue_radicand(64'h8000_0000_0000_0000, 1'b0);
    queue_radicand(64'h8000_0000_0000_0001, 1'b0);
    queue_radicand(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_radicand(64'(ROOT_MAX) * 64'(ROOT_MAX), 1'b0);
    queue_radicand(64'(ROOT_MAX) * 64'(ROOT_MAX) - 64'd1, 1'b0);
    queue_radicand(64'h4000_0000_0000_0000, 1'b0);
    queue_radicand(64'h3FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_radicand(64'h0000_0001_0000_0000, 1'b0);
    queue_radicand(64'h0000_0000_FFFF_FFFF, 1'b0);
    queue_radicand(64'h5555_5555_5555_5555, 1'b0);
    queue_radicand(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_radicand(64'd99, 1'b0);
    queue_radicand(64'd100, 1'b0);
    queue_radicand(64'hFFFF_FFFF_0000_0000, 1'b0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      sel = $urandom_range(9);
      r = 64'($urandom_range(ROOT_MAX, 0));
      case (sel)
        0, 1, 2: r = {$urandom, $urandom};
        3, 4:    r = r * r;
        5:       r = r * r - 64'd1;
        6:       r = r * r + 2 * r;
        7:       r = 64'($urandom_range(300, 0));
        8:       r = {1'b1, 31'($urandom), $urandom};
        default: r = (64'd1 << $urandom_range(62, 0)) - 64'($urandom_range(1, 0));
      endcase
      queue_radicand(r, i == 0 || i == 330 || i == 680);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_radicands.size() != 0 || in_valid_i) @(posedge clk_i);
    while (roots_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> integer_square_root.f
+incdir+src
src/isr_pkg.sv
src/isr_datapath.sv
src/isr_ctrl.sv
src/integer_square_root.sv
sim/tb_integer_square_root.sv
